// ===== src/lbvs_pkg.sv =====
// Package for the linear blend vertex skinning block.
// Holds the transaction structs, codes, constants and saturation helpers.
// No dependencies.
package lbvs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int MAX_LINKS      = 4;
  localparam int AXES           = 3;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Operation codes carried in the op field
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SKIN = 1'b1;

  typedef struct packed {
    logic               op;
    logic [3:0]         slot;
    logic [6:0]         bone_a;
    logic [6:0]         bone_b;
    logic [6:0]         bone_c;
    logic [6:0]         bone_d;
    logic [16:0]        weight_a;
    logic [16:0]        weight_b;
    logic [16:0]        weight_c;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } vtx_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } res_t;

  // Advance enables for the three stages of the bone transform
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } xform_en_t;

  function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
    logic signed [31:0] r;
    if (v > 51'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/lbvs_ram.sv =====
// One bank of the bone matrix store: one word of every bone.
// Single write port, single read port with registered data. No dependencies.
module lbvs_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lbvs_xform.sv =====
// Affine transform of one position by one bone matrix, three register stages.
// Depends on lbvs_pkg for the enable struct and saturation.
module lbvs_xform (
  input  logic                          clk,
  input  lbvs_pkg::xform_en_t           en,
  input  logic [11:0][31:0]             m,
  input  logic [2:0][31:0]              pos,
  output logic [2:0][31:0]              t
);
  import lbvs_pkg::*;

  logic signed [63:0] prod [AXES][3];
  logic signed [31:0] m3_s2 [AXES];
  logic signed [65:0] sum [AXES];
  logic signed [31:0] m3_s3 [AXES];
  logic signed [50:0] tr [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    always_ff @(posedge clk) begin
      if (en.en2) begin
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= $signed(pos[k]) * $signed(m[a*4 + k]);
        end
        m3_s2[a] <= $signed(m[a*4 + 3]);
      end
    end

    // Fold the rounding half into the product sum
    always_ff @(posedge clk) begin
      if (en.en3) begin
        sum[a]   <= 66'(prod[a][0]) + 66'(prod[a][1]) + 66'(prod[a][2]) + 66'sd32768;
        m3_s3[a] <= m3_s2[a];
      end
    end

    assign tr[a] = $signed({sum[a][65], sum[a][65:16]}) +
                   $signed({{19{m3_s3[a][31]}}, m3_s3[a]});

    always_ff @(posedge clk) begin
      if (en.en4) begin
        t[a] <= sat51(tr[a]);
      end
    end
  end

endmodule

// ===== src/linear_blend_vertex_skinning.sv =====
// Top level of the linear blend vertex skinning block.
// Depends on lbvs_pkg, lbvs_ram and lbvs_xform.
//
// One transaction is taken every clock cycle while the result side keeps up.
// A load writes one matrix word and gives no result; a skin transaction gives
// one result via the matrix read, transform, weighting and output stages. The
// matrix store is replicated once per link and banked by word, so all 48 words
// of a vertex are read at once, and each stage holds independently, so bubbles
// are squeezed out while the result side stalls. A skin transaction sees every
// load taken before it. Write link_count only while the block is idle.
module linear_blend_vertex_skinning #(
  parameter int MAX_BONES = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vtx_valid,
  output logic            vtx_stall,
  input  lbvs_pkg::vtx_t  vtx,
  output logic            res_valid,
  input  logic            res_stall,
  output lbvs_pkg::res_t  res,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_data
);
  import lbvs_pkg::*;

  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  logic [2:0] link_count;

  logic en1, en2, en3, en4, en5, en6;
  logic v1, v2, v3, v4, v5;
  logic accept;

  logic [AW-1:0] mod_tab [128];
  logic [6:0]    bone [MAX_LINKS];

  logic [16:0] wa, wb, wc;
  logic signed [18:0] wa_s, wb_s, wc_s;
  logic signed [18:0] w_in [MAX_LINKS];
  logic [MAX_LINKS-1:0] used_in;

  logic signed [18:0] w_s1 [MAX_LINKS];
  logic signed [18:0] w_s2 [MAX_LINKS];
  logic signed [18:0] w_s3 [MAX_LINKS];
  logic signed [18:0] w_s4 [MAX_LINKS];
  logic [MAX_LINKS-1:0] used_s1, used_s2, used_s3, used_s4;
  logic [2:0][31:0] pos_s1;

  logic [11:0][31:0] mword [MAX_LINKS];
  logic [2:0][31:0]  tpt [MAX_LINKS];
  logic signed [50:0] term [MAX_LINKS][AXES];
  logic signed [52:0] acc [AXES];

  xform_en_t xen;

  // Bone index modulo MAX_BONES, worked out at elaboration
  for (genvar g = 0; g < 128; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % MAX_BONES);
  end

  assign bone[0] = vtx.bone_a;
  assign bone[1] = vtx.bone_b;
  assign bone[2] = vtx.bone_c;
  assign bone[3] = vtx.bone_d;

  // Handshake: each stage advances when empty or when the next one advances
  assign en6       = !res_valid || !res_stall;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign vtx_stall = !en1;
  assign accept    = vtx_valid && en1;

  assign xen.en2 = en2;
  assign xen.en3 = en3;
  assign xen.en4 = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_count <= 3'd1;
    end else if (cfg_we) begin
      link_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) v1 <= accept && (vtx.op == OP_SKIN);
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) res_valid <= v5;
    end
  end

  // Weights: clamp to one; the last link (first if two) takes one minus the rest
  always_comb begin
    wa   = (vtx.weight_a > ONE_Q16) ? ONE_Q16 : vtx.weight_a;
    wb   = (vtx.weight_b > ONE_Q16) ? ONE_Q16 : vtx.weight_b;
    wc   = (vtx.weight_c > ONE_Q16) ? ONE_Q16 : vtx.weight_c;
    wa_s = $signed({2'b00, wa});
    wb_s = $signed({2'b00, wb});
    wc_s = $signed({2'b00, wc});
    for (int i = 0; i < MAX_LINKS; i++) begin
      w_in[i] = '0;
    end
    case (link_count) inside
      3'd0, 3'd1: begin
        w_in[0] = $signed({2'b00, ONE_Q16});
        used_in = 4'b0001;
      end
      3'd2: begin
        w_in[0] = $signed({2'b00, ONE_Q16}) - wa_s;
        w_in[1] = wa_s;
        used_in = 4'b0011;
      end
      3'd3: begin
        w_in[0] = wa_s;
        w_in[1] = wb_s;
        w_in[2] = $signed({2'b00, ONE_Q16}) - wa_s - wb_s;
        used_in = 4'b0111;
      end
      default: begin
        w_in[0] = wa_s;
        w_in[1] = wb_s;
        w_in[2] = wc_s;
        w_in[3] = $signed({2'b00, ONE_Q16}) - wa_s - wb_s - wc_s;
        used_in = 4'b1111;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      w_s1    <= w_in;
      used_s1 <= used_in;
      pos_s1  <= {vtx.pos_z, vtx.pos_y, vtx.pos_x};
    end
    if (en2) begin
      w_s2    <= w_s1;
      used_s2 <= used_s1;
    end
    if (en3) begin
      w_s3    <= w_s2;
      used_s3 <= used_s2;
    end
    if (en4) begin
      w_s4    <= w_s3;
      used_s4 <= used_s3;
    end
  end

  for (genvar l = 0; l < MAX_LINKS; l++) begin : g_link
    for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_word
      lbvs_ram #(
        .DEPTH (MAX_BONES),
        .AW    (AW)
      ) u_ram (
        .clk   (clk),
        .we    (accept && (vtx.op == OP_LOAD) && (vtx.slot == 4'(k))),
        .waddr (mod_tab[vtx.bone_a]),
        .wdata (vtx.pos_x),
        .re    (en1),
        .raddr (mod_tab[bone[l]]),
        .rdata (mword[l][k])
      );
    end

    lbvs_xform u_xform (
      .clk (clk),
      .en  (xen),
      .m   (mword[l]),
      .pos (pos_s1),
      .t   (tpt[l])
    );

    // Drop unused links so the bones they name never reach the sum
    for (genvar a = 0; a < AXES; a++) begin : g_term
      always_ff @(posedge clk) begin
        if (en5) begin
          term[l][a] <= used_s4[l] ? w_s4[l] * $signed(tpt[l][a]) : 51'sd0;
        end
      end
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_acc
    assign acc[a] = 53'(term[0][a]) + 53'(term[1][a]) + 53'(term[2][a]) +
                    53'(term[3][a]) + 53'sd32768;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      res.out_x <= sat37(acc[0][52:16]);
      res.out_y <= sat37(acc[1][52:16]);
      res.out_z <= sat37(acc[2][52:16]);
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    vtx_stall |-> (v1 && v2 && v3 && v4 && v5 && res_valid))
    else $error("input stalled with a free pipeline stage");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (vtx_valid && !vtx_stall && vtx.op == OP_LOAD) |=> !v1)
    else $error("load transaction entered the skin pipeline");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(v5))
    else $error("result appeared without a transaction in the last stage");

  a_hold_last_stage: assert property (@(posedge clk) disable iff (rst)
    (v5 && !en5) |=> v5)
    else $error("held transaction lost from the last stage");

endmodule
